/* rtl/rpba_pkg.sv */
// Shared types, constants and command codes for the regular polygon bounding box block.
// Used by rpba_ctrl, rpba_dp and regular_polygon_bounding_box_area. No dependencies.
`default_nettype none
package rpba_pkg;

	localparam int MAX_SIDES    = 64;
	localparam int CORDIC_STEPS = 24;
	localparam int DIV_STEPS    = 64;
	localparam int IN_W         = 200;
	localparam int OUT_W        = 64;
	localparam int USER_W       = 2;

	localparam logic [33:0] CORDIC_GAIN  = 34'd652032875;
	localparam logic [33:0] HALF_PI      = 34'd1686629713;
	localparam logic [40:0] OFFSET_LIMIT = 41'h100_0000_0000;

	// multiplier operand A
	localparam logic [3:0] A_UX  = 4'd0;
	localparam logic [3:0] A_UY  = 4'd1;
	localparam logic [3:0] A_VX  = 4'd2;
	localparam logic [3:0] A_VY  = 4'd3;
	localparam logic [3:0] A_UUL = 4'd4;
	localparam logic [3:0] A_UUH = 4'd5;
	localparam logic [3:0] A_VVL = 4'd6;
	localparam logic [3:0] A_VVH = 4'd7;
	localparam logic [3:0] A_RES = 4'd8;
	localparam logic [3:0] A_DX  = 4'd9;
	localparam logic [3:0] A_DY  = 4'd10;
	localparam logic [3:0] A_WL  = 4'd11;
	localparam logic [3:0] A_WH  = 4'd12;

	// multiplier operand B
	localparam logic [3:0] B_UX  = 4'd0;
	localparam logic [3:0] B_UY  = 4'd1;
	localparam logic [3:0] B_VX  = 4'd2;
	localparam logic [3:0] B_VY  = 4'd3;
	localparam logic [3:0] B_HPI = 4'd4;
	localparam logic [3:0] B_C   = 4'd5;
	localparam logic [3:0] B_S   = 4'd6;
	localparam logic [3:0] B_HL  = 4'd7;
	localparam logic [3:0] B_HH  = 4'd8;

	// accumulator operations
	localparam logic [2:0] ACC_NOP   = 3'd0;
	localparam logic [2:0] ACC_LOAD  = 3'd1;
	localparam logic [2:0] ACC_LOADR = 3'd2;
	localparam logic [2:0] ACC_ADD   = 3'd3;
	localparam logic [2:0] ACC_SUB   = 3'd4;

	localparam logic [1:0] SH_0  = 2'd0;
	localparam logic [1:0] SH_32 = 2'd1;
	localparam logic [1:0] SH_64 = 2'd2;

	// store targets: accumulator slices, or box width and height for ST_WH
	localparam logic [2:0] ST_NONE = 3'd0;
	localparam logic [2:0] ST_DET  = 3'd1;
	localparam logic [2:0] ST_UU   = 3'd2;
	localparam logic [2:0] ST_VV   = 3'd3;
	localparam logic [2:0] ST_NX   = 3'd4;
	localparam logic [2:0] ST_NY   = 3'd5;
	localparam logic [2:0] ST_RX   = 3'd6;
	localparam logic [2:0] ST_WH   = 3'd7;

	// division jobs
	localparam logic [1:0] DIV_PX   = 2'd0;
	localparam logic [1:0] DIV_PY   = 2'd1;
	localparam logic [1:0] DIV_TURN = 2'd2;

	typedef struct packed {
		logic       load;
		logic [3:0] a_sel;
		logic [3:0] b_sel;
		logic [2:0] acc_op;
		logic [1:0] acc_sh;
		logic [2:0] st;
		logic       div_start;
		logic       div_step;
		logic       div_end;
		logic [1:0] dix;
		logic       cord_init;
		logic       cord_step;
		logic [4:0] cord_idx;
		logic       cs_load;
		logic       box_upd;
		logic       box_first;
		logic       out_load;
	} cmd_t;

	typedef struct packed {
		logic       det_zero;
		logic [6:0] n;
	} stat_t;

	function automatic logic [33:0] atan_q30(input logic [4:0] idx);
		logic [33:0] r;
		case (idx)
			5'd0:  r = 34'd843314857;
			5'd1:  r = 34'd497837830;
			5'd2:  r = 34'd263043837;
			5'd3:  r = 34'd133525159;
			5'd4:  r = 34'd67021687;
			5'd5:  r = 34'd33543515;
			5'd6:  r = 34'd16775851;
			5'd7:  r = 34'd8388437;
			5'd8:  r = 34'd4194283;
			5'd9:  r = 34'd2097149;
			5'd31: r = 34'd0;
			default: r = 34'd1 << (5'd30 - idx);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/rpba_ctrl.sv */
// Sequencer for the bounding box block: issues datapath commands step by step.
// Depends on rpba_pkg for cmd_t, stat_t and the command codes.
`default_nettype none
module rpba_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_fire,
	input  wire logic           out_free,
	input  wire rpba_pkg::stat_t stat,
	output logic                in_ready,
	output rpba_pkg::cmd_t      cmd
);
	import rpba_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_PREP   = 4'd1;
	localparam logic [3:0] S_CHK    = 4'd2;
	localparam logic [3:0] S_DSTART = 4'd3;
	localparam logic [3:0] S_DIV    = 4'd4;
	localparam logic [3:0] S_DEND   = 4'd5;
	localparam logic [3:0] S_VA     = 4'd6;
	localparam logic [3:0] S_VB     = 4'd7;
	localparam logic [3:0] S_VC     = 4'd8;
	localparam logic [3:0] S_VD     = 4'd9;
	localparam logic [3:0] S_VM     = 4'd10;
	localparam logic [3:0] S_AREA   = 4'd11;
	localparam logic [3:0] S_FIN    = 4'd12;

	localparam logic [5:0] PREP_LAST = 6'd17;
	localparam logic [5:0] MAC_LAST  = 6'd5;
	localparam logic [5:0] CORD_LAST = 6'(CORDIC_STEPS - 1);
	localparam logic [5:0] DIV_LAST  = 6'(DIV_STEPS - 1);

	logic [3:0] state_q;
	logic [5:0] cnt_q;
	logic [1:0] dix_q;
	logic [6:0] vi_q;
	logic       last_vtx;

	assign in_ready = (state_q == S_IDLE);
	assign last_vtx = (vi_q == (stat.n - 7'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			dix_q   <= DIV_PX;
			vi_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= S_PREP;
						cnt_q   <= '0;
					end
				end
				S_PREP: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == PREP_LAST) begin
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					cnt_q <= '0;
					dix_q <= DIV_PX;
					state_q <= stat.det_zero ? S_FIN : S_DIV;
				end
				S_DSTART: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == DIV_LAST) begin
						state_q <= S_DEND;
					end
				end
				S_DEND: begin
					if (dix_q == DIV_TURN) begin
						vi_q    <= '0;
						state_q <= S_VA;
					end else begin
						dix_q   <= dix_q + 2'd1;
						state_q <= S_DSTART;
					end
				end
				S_VA: begin
					state_q <= S_VB;
				end
				S_VB: begin
					cnt_q   <= '0;
					state_q <= S_VC;
				end
				S_VC: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == CORD_LAST) begin
						state_q <= S_VD;
					end
				end
				S_VD: begin
					cnt_q   <= '0;
					state_q <= S_VM;
				end
				S_VM: begin
					if (cnt_q == MAC_LAST) begin
						cnt_q <= '0;
						vi_q  <= vi_q + 7'd1;
						state_q <= last_vtx ? S_AREA : S_VA;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				S_AREA: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == MAC_LAST) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		cmd          = '0;
		cmd.a_sel    = A_UX;
		cmd.b_sel    = B_UX;
		cmd.acc_op   = ACC_NOP;
		cmd.acc_sh   = SH_0;
		cmd.st       = ST_NONE;
		cmd.dix      = dix_q;
		cmd.cord_idx = cnt_q[4:0];
		case (state_q)
			S_IDLE: begin
				cmd.load = in_fire;
			end
			S_PREP: begin
				case (cnt_q)
					6'd0: begin
						cmd.a_sel = A_UX; cmd.b_sel = B_VY;
					end
					6'd1: begin
						cmd.a_sel = A_VX; cmd.b_sel = B_UY; cmd.acc_op = ACC_LOAD;
					end
					6'd2: begin
						cmd.a_sel = A_UX; cmd.b_sel = B_UX; cmd.acc_op = ACC_SUB;
					end
					6'd3: begin
						cmd.a_sel = A_UY; cmd.b_sel = B_UY; cmd.acc_op = ACC_LOAD;
						cmd.st = ST_DET;
					end
					6'd4: begin
						cmd.a_sel = A_VX; cmd.b_sel = B_VX; cmd.acc_op = ACC_ADD;
					end
					6'd5: begin
						cmd.a_sel = A_VY; cmd.b_sel = B_VY; cmd.acc_op = ACC_LOAD;
						cmd.st = ST_UU;
					end
					6'd6: begin
						cmd.acc_op = ACC_ADD;
					end
					6'd7: begin
						cmd.a_sel = A_UUL; cmd.b_sel = B_VY; cmd.st = ST_VV;
					end
					6'd8: begin
						cmd.a_sel = A_UUH; cmd.b_sel = B_VY; cmd.acc_op = ACC_LOAD;
					end
					6'd9: begin
						cmd.a_sel = A_VVL; cmd.b_sel = B_UY; cmd.acc_op = ACC_ADD;
						cmd.acc_sh = SH_32;
					end
					6'd10: begin
						cmd.a_sel = A_VVH; cmd.b_sel = B_UY; cmd.acc_op = ACC_SUB;
					end
					6'd11: begin
						cmd.acc_op = ACC_SUB; cmd.acc_sh = SH_32;
					end
					6'd12: begin
						cmd.a_sel = A_VVL; cmd.b_sel = B_UX; cmd.st = ST_NX;
					end
					6'd13: begin
						cmd.a_sel = A_VVH; cmd.b_sel = B_UX; cmd.acc_op = ACC_LOAD;
					end
					6'd14: begin
						cmd.a_sel = A_UUL; cmd.b_sel = B_VX; cmd.acc_op = ACC_ADD;
						cmd.acc_sh = SH_32;
					end
					6'd15: begin
						cmd.a_sel = A_UUH; cmd.b_sel = B_VX; cmd.acc_op = ACC_SUB;
					end
					6'd16: begin
						cmd.acc_op = ACC_SUB; cmd.acc_sh = SH_32;
					end
					6'd17: begin
						cmd.st = ST_NY;
					end
					default: begin
						cmd.acc_op = ACC_NOP;
					end
				endcase
			end
			S_CHK: begin
				cmd.div_start = !stat.det_zero;
				cmd.dix       = DIV_PX;
			end
			S_DSTART: begin
				cmd.div_start = 1'b1;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			S_DEND: begin
				cmd.div_end = 1'b1;
			end
			S_VA: begin
				cmd.a_sel = A_RES; cmd.b_sel = B_HPI;
			end
			S_VB: begin
				cmd.cord_init = 1'b1;
			end
			S_VC: begin
				cmd.cord_step = 1'b1;
			end
			S_VD: begin
				cmd.cs_load = 1'b1;
			end
			S_VM: begin
				case (cnt_q)
					6'd0: begin
						cmd.a_sel = A_DX; cmd.b_sel = B_C;
					end
					6'd1: begin
						cmd.a_sel = A_DY; cmd.b_sel = B_S; cmd.acc_op = ACC_LOADR;
					end
					6'd2: begin
						cmd.a_sel = A_DX; cmd.b_sel = B_S; cmd.acc_op = ACC_SUB;
					end
					6'd3: begin
						cmd.a_sel = A_DY; cmd.b_sel = B_C; cmd.acc_op = ACC_LOADR;
						cmd.st = ST_RX;
					end
					6'd4: begin
						cmd.acc_op = ACC_ADD;
					end
					6'd5: begin
						cmd.box_upd   = 1'b1;
						cmd.box_first = (vi_q == 7'd0);
					end
					default: begin
						cmd.acc_op = ACC_NOP;
					end
				endcase
			end
			S_AREA: begin
				case (cnt_q)
					6'd0: begin
						cmd.st = ST_WH;
					end
					6'd1: begin
						cmd.a_sel = A_WL; cmd.b_sel = B_HL;
					end
					6'd2: begin
						cmd.a_sel = A_WL; cmd.b_sel = B_HH; cmd.acc_op = ACC_LOAD;
					end
					6'd3: begin
						cmd.a_sel = A_WH; cmd.b_sel = B_HL; cmd.acc_op = ACC_ADD;
						cmd.acc_sh = SH_32;
					end
					6'd4: begin
						cmd.a_sel = A_WH; cmd.b_sel = B_HH; cmd.acc_op = ACC_ADD;
						cmd.acc_sh = SH_32;
					end
					6'd5: begin
						cmd.acc_op = ACC_ADD; cmd.acc_sh = SH_64;
					end
					default: begin
						cmd.acc_op = ACC_NOP;
					end
				endcase
			end
			S_FIN: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd.load = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

/* rtl/rpba_dp.sv */
// Datapath: shared multiplier and accumulator, restoring divider, CORDIC unit, box tracker.
// Depends on rpba_pkg; driven by commands from rpba_ctrl.
`default_nettype none
module rpba_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [rpba_pkg::IN_W-1:0]    in_data,
	input  wire rpba_pkg::cmd_t               cmd,
	output rpba_pkg::stat_t                   stat,
	output logic [rpba_pkg::OUT_W-1:0]        res_area,
	output logic                              res_degenerate,
	output logic                              res_saturated
);
	import rpba_pkg::*;

	logic signed [31:0] ax_in, ay_in, bx_in, by_in, cx_in, cy_in;
	logic        [6:0]  sides_in;
	logic signed [32:0] dbx, dby, dcx, dcy;

	logic signed [31:0] ax_q, ay_q, ux_q, uy_q, vx_q, vy_q;
	logic        [6:0]  n_q;
	logic               sat_q;
	logic signed [63:0] det_q;
	logic        [63:0] uu_q, vv_q;
	logic signed [96:0] nx_q, ny_q;
	logic signed [33:0] op_a, op_b;
	logic signed [67:0] prod_s1;
	logic signed [97:0] acc_q, pext, pv;

	logic        [63:0] rem_q, lo_q, q_q, d_q;
	logic               neg_q, big_q;
	logic signed [96:0] dnum;
	logic        [96:0] dmag;
	logic        [63:0] dden;
	logic               dneg;
	logic        [64:0] dtrial;
	logic               dge;
	logic        [40:0] qmag;
	logic               qover;
	logic signed [41:0] qsig;
	logic signed [42:0] osum;
	logic signed [31:0] oclamp;
	logic               oclip;

	logic        [31:0] turn_q, stp_q;
	logic        [6:0]  trem_q, srem_q;
	logic        [7:0]  tsum;
	logic               tcarry;

	logic signed [32:0] dx_q, dy_q;
	logic signed [33:0] x_q, y_q, z_q, c_q, s_q, xs, ys;
	logic        [67:0] zsum;

	logic signed [35:0] rx_q, ryv, minx_q, maxx_q, miny_q, maxy_q;
	logic        [35:0] w_q, h_q;
	logic               ovf;

	assign ax_in    = in_data[31:0];
	assign ay_in    = in_data[63:32];
	assign bx_in    = in_data[95:64];
	assign by_in    = in_data[127:96];
	assign cx_in    = in_data[159:128];
	assign cy_in    = in_data[191:160];
	assign sides_in = in_data[198:192];

	assign dbx = 33'(bx_in) - 33'(ax_in);
	assign dby = 33'(by_in) - 33'(ay_in);
	assign dcx = 33'(cx_in) - 33'(ax_in);
	assign dcy = 33'(cy_in) - 33'(ay_in);

	assign stat.det_zero = (det_q == 64'sd0);
	assign stat.n        = n_q;

	always_comb begin
		case (cmd.a_sel)
			A_UX:    op_a = 34'(ux_q);
			A_UY:    op_a = 34'(uy_q);
			A_VX:    op_a = 34'(vx_q);
			A_VY:    op_a = 34'(vy_q);
			A_UUL:   op_a = {2'b00, uu_q[31:0]};
			A_UUH:   op_a = {2'b00, uu_q[63:32]};
			A_VVL:   op_a = {2'b00, vv_q[31:0]};
			A_VVH:   op_a = {2'b00, vv_q[63:32]};
			A_RES:   op_a = {4'b0000, turn_q[29:0]};
			A_DX:    op_a = 34'(dx_q);
			A_DY:    op_a = 34'(dy_q);
			A_WL:    op_a = {2'b00, w_q[31:0]};
			A_WH:    op_a = {30'd0, w_q[35:32]};
			default: op_a = '0;
		endcase
		case (cmd.b_sel)
			B_UX:    op_b = 34'(ux_q);
			B_UY:    op_b = 34'(uy_q);
			B_VX:    op_b = 34'(vx_q);
			B_VY:    op_b = 34'(vy_q);
			B_HPI:   op_b = HALF_PI;
			B_C:     op_b = c_q;
			B_S:     op_b = s_q;
			B_HL:    op_b = {2'b00, h_q[31:0]};
			B_HH:    op_b = {30'd0, h_q[35:32]};
			default: op_b = '0;
		endcase
	end

	assign pext = {{30{prod_s1[67]}}, prod_s1};

	always_comb begin
		case (cmd.acc_sh)
			SH_32:   pv = pext <<< 32;
			SH_64:   pv = pext <<< 64;
			default: pv = pext;
		endcase
	end

	// divider operand selection
	always_comb begin
		case (cmd.dix)
			DIV_PX:   dnum = nx_q;
			DIV_PY:   dnum = ny_q;
			default:  dnum = 97'sd4294967296;
		endcase
		dmag = dnum[96] ? 97'(-dnum) : 97'(dnum);
		if (cmd.dix == DIV_TURN) begin
			dden = {57'd0, n_q};
			dneg = 1'b0;
		end else begin
			dden = det_q[63] ? 64'(-det_q) : 64'(det_q);
			dneg = dnum[96] ^ det_q[63];
		end
	end

	assign dtrial = {rem_q, lo_q[63]};
	assign dge    = (dtrial >= {1'b0, d_q});

	always_comb begin
		qover = 1'b0;
		if (big_q) begin
			qmag = OFFSET_LIMIT;
		end else if (q_q > 64'(OFFSET_LIMIT)) begin
			qmag  = OFFSET_LIMIT;
			qover = 1'b1;
		end else begin
			qmag = q_q[40:0];
		end
		qsig = neg_q ? -42'(qmag) : 42'(qmag);
		if (cmd.dix == DIV_PX) begin
			osum = 43'(ax_q) + 43'(qsig);
		end else begin
			osum = 43'(ay_q) + 43'(qsig);
		end
		oclip = 1'b1;
		if (osum > 43'sd2147483647) begin
			oclamp = 32'sh7FFF_FFFF;
		end else if (osum < -43'sd2147483648) begin
			oclamp = 32'sh8000_0000;
		end else begin
			oclamp = osum[31:0];
			oclip  = 1'b0;
		end
	end

	assign tsum   = {1'b0, trem_q} + {1'b0, srem_q};
	assign tcarry = (tsum >= {1'b0, n_q});

	assign xs   = x_q >>> cmd.cord_idx;
	assign ys   = y_q >>> cmd.cord_idx;
	assign zsum = prod_s1 + 68'sd536870912;
	assign ryv  = acc_q[65:30];

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;

		if (cmd.load) begin
			ax_q <= ax_in;
			ay_q <= ay_in;
			ux_q <= dbx[32:1];
			uy_q <= dby[32:1];
			vx_q <= dcx[32:1];
			vy_q <= dcy[32:1];
			if (sides_in < 7'd3) begin
				n_q <= 7'd3;
			end else if (sides_in > 7'(MAX_SIDES)) begin
				n_q <= 7'(MAX_SIDES);
			end else begin
				n_q <= sides_in;
			end
		end

		case (cmd.acc_op)
			ACC_LOAD:  acc_q <= pv;
			ACC_LOADR: acc_q <= pv + 98'sd536870912;
			ACC_ADD:   acc_q <= acc_q + pv;
			ACC_SUB:   acc_q <= acc_q - pv;
			default:   acc_q <= acc_q;
		endcase

		case (cmd.st)
			ST_DET: det_q <= acc_q[63:0];
			ST_UU:  uu_q  <= acc_q[63:0];
			ST_VV:  vv_q  <= acc_q[63:0];
			ST_NX:  nx_q  <= acc_q[96:0];
			ST_NY:  ny_q  <= acc_q[96:0];
			ST_RX:  rx_q  <= acc_q[65:30];
			ST_WH: begin
				w_q <= 36'(maxx_q - minx_q);
				h_q <= 36'(maxy_q - miny_q);
			end
			default: begin
				w_q <= w_q;
			end
		endcase

		if (cmd.div_start) begin
			rem_q <= {31'd0, dmag[96:64]};
			lo_q  <= dmag[63:0];
			q_q   <= '0;
			d_q   <= dden;
			neg_q <= dneg;
			big_q <= ({31'd0, dmag[96:64]} >= dden);
		end else if (cmd.div_step) begin
			rem_q <= dge ? 64'(dtrial - {1'b0, d_q}) : dtrial[63:0];
			lo_q  <= {lo_q[62:0], 1'b0};
			q_q   <= {q_q[62:0], dge};
		end

		if (cmd.div_end) begin
			case (cmd.dix)
				DIV_PX: begin
					dx_q <= 33'(ax_q) - 33'(oclamp);
				end
				DIV_PY: begin
					dy_q <= 33'(ay_q) - 33'(oclamp);
				end
				default: begin
					stp_q  <= q_q[31:0];
					srem_q <= rem_q[6:0];
					turn_q <= '0;
					trem_q <= '0;
				end
			endcase
		end else if (cmd.box_upd) begin
			turn_q <= turn_q + stp_q + {31'd0, tcarry};
			trem_q <= tcarry ? 7'(tsum - {1'b0, n_q}) : tsum[6:0];
		end

		if (cmd.cord_init) begin
			z_q <= zsum[63:30];
			x_q <= CORDIC_GAIN;
			y_q <= '0;
		end else if (cmd.cord_step) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_q30(cmd.cord_idx);
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_q30(cmd.cord_idx);
			end
		end

		if (cmd.cs_load) begin
			case (turn_q[31:30])
				2'd0: begin c_q <= x_q;  s_q <= y_q;  end
				2'd1: begin c_q <= -y_q; s_q <= x_q;  end
				2'd2: begin c_q <= -x_q; s_q <= -y_q; end
				default: begin c_q <= y_q; s_q <= -x_q; end
			endcase
		end

		if (cmd.box_upd) begin
			if (cmd.box_first || rx_q < minx_q) minx_q <= rx_q;
			if (cmd.box_first || rx_q > maxx_q) maxx_q <= rx_q;
			if (cmd.box_first || ryv < miny_q)  miny_q <= ryv;
			if (cmd.box_first || ryv > maxy_q)  maxy_q <= ryv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.load) begin
			sat_q <= 1'b0;
		end else if (cmd.div_end && cmd.dix != DIV_TURN) begin
			sat_q <= sat_q | qover | oclip;
		end
	end

	assign ovf = (acc_q[97:64] != '0);

	always_comb begin
		if (stat.det_zero) begin
			res_area       = '0;
			res_degenerate = 1'b1;
			res_saturated  = 1'b0;
		end else begin
			res_area       = ovf ? '1 : acc_q[63:0];
			res_degenerate = 1'b0;
			res_saturated  = sat_q | ovf;
		end
	end

endmodule
`default_nettype wire

/* rtl/regular_polygon_bounding_box_area.sv */
// Sequence: unless the input is degenerate, one restoring divider bit per cycle for three
// 64-step divisions, then per vertex a 24-step CORDIC plus a 6-step multiply pass on the
// single shared multiplier. One item at a time; a new item is accepted only once the last is done.
// A finished result waits in the output register while the next item runs.
// Reset clears the sequencer and output valid; no state survives between items.
`default_nettype none
module regular_polygon_bounding_box_area (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// ax, ay, bx, by_coord, cx, cy (32 each), sides (7), zero pad (1)
	input  wire logic [rpba_pkg::IN_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// area (64)
	output logic [rpba_pkg::OUT_W-1:0]         m_tdata,
	// degenerate (1), saturated (1)
	output logic [rpba_pkg::USER_W-1:0]        m_tuser
);
	import rpba_pkg::*;

	cmd_t             cmd;
	stat_t            stat;
	logic             in_fire;
	logic             out_free;
	logic [OUT_W-1:0] res_area;
	logic             res_degenerate;
	logic             res_saturated;
	logic             m_tvalid_q;
	logic [OUT_W-1:0] area_q;
	logic [1:0]       user_q;

	assign in_fire  = s_tvalid & s_tready;
	assign out_free = !m_tvalid_q | m_tready;

	rpba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.stat     (stat),
		.in_ready (s_tready),
		.cmd      (cmd)
	);

	rpba_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_data        (s_tdata),
		.cmd            (cmd),
		.stat           (stat),
		.res_area       (res_area),
		.res_degenerate (res_degenerate),
		.res_saturated  (res_saturated)
	);

	// hold the result until the downstream transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			area_q <= res_area;
			user_q <= {res_saturated, res_degenerate};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = area_q;
	assign m_tuser  = user_q;

endmodule
`default_nettype wire
